// File: rtl/core/mqrbf_pkg.sv
// Shared widths, operator codes and pipeline sideband type for the multiquadric RBF kernel.
package mqrbf_pkg;

	// coordinate and fixed-point format
	localparam int CW   = 32;            // coordinate bits taken from each input
	localparam int FB   = 16;            // fraction bits
	localparam int SPW  = 31;            // shape parameter width
	localparam int OW   = 32;            // result width

	// derived datapath widths
	localparam int DW   = CW + 1;        // signed coordinate difference
	localparam int C2W  = 2 * SPW;       // c squared
	localparam int SW   = (2 * CW + 2 > 2 * SPW + 1) ? 2 * CW + 2 : 2 * SPW + 1;
	localparam int RW   = (SW + 1) / 2;  // root bits needed for S
	localparam int Q1W  = 2 * FB + 1;    // quotient bits of c^2 * 2^(2FB) / S
	localparam int NST  = (RW > Q1W) ? RW : Q1W;
	localparam int SEW  = 2 * NST;       // S, zero extended to whole root digit pairs
	localparam int RMW  = NST + 2;       // root remainder
	localparam int QW   = NST + 1;       // rounded root
	localparam int NW   = C2W + 2 * FB;  // first dividend
	localparam int Q2W  = 2 * FB + 2;    // final quotient bits
	localparam int N2W  = (NST + 3 > CW + FB + 2) ? NST + 3 : CW + FB + 2;
	localparam int D2W  = QW + 1;        // final divisor, twice the root
	localparam int MW   = (QW > Q2W) ? QW : Q2W;

	localparam logic [SPW-1:0] SHAPE_RESET = SPW'(1) << FB;

	typedef enum logic [1:0] {
		OP_IDENT   = 2'd0,
		OP_LAPLACE = 2'd1,
		OP_XPART   = 2'd2,
		OP_YPART   = 2'd3
	} op_t;

	// item context that rides along the arithmetic stages
	typedef struct packed {
		op_t             op;
		logic            neg;
		logic            szero;
		logic [CW-1:0]   dmag;
		logic [QW-1:0]   q;
	} side_t;

endpackage

// File: rtl/core/mqrbf_root_div.sv
// Pipelined square root of S alongside the restoring division c^2 * 2^(2FB) / S.
module mqrbf_root_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_v,
	input  logic [mqrbf_pkg::SEW-1:0]     in_s,
	input  logic [mqrbf_pkg::C2W-1:0]     in_c2,
	input  mqrbf_pkg::side_t              in_side,
	output logic                          out_v,
	output logic [mqrbf_pkg::NST-1:0]     out_root,
	output logic [mqrbf_pkg::RMW-1:0]     out_rrem,
	output logic [mqrbf_pkg::NST-1:0]     out_quo,
	output mqrbf_pkg::side_t              out_side
);

	localparam int NST = mqrbf_pkg::NST;
	localparam int SEW = mqrbf_pkg::SEW;
	localparam int RMW = mqrbf_pkg::RMW;
	localparam int NW  = mqrbf_pkg::NW;
	localparam int FB  = mqrbf_pkg::FB;

	logic [NW-1:0] num1;

	// stage inputs
	logic [SEW-1:0]     ci_s    [0:NST-1];
	logic [NST-1:0]     ci_root [0:NST-1];
	logic [RMW-1:0]     ci_rrem [0:NST-1];
	logic [NST-1:0]     ci_nlo  [0:NST-1];
	logic [SEW-1:0]     ci_rem  [0:NST-1];
	logic [NST-1:0]     ci_quo  [0:NST-1];
	mqrbf_pkg::side_t   ci_side [0:NST-1];

	// stage results
	logic [NST-1:0]     n_root  [0:NST-1];
	logic [RMW-1:0]     n_rrem  [0:NST-1];
	logic [SEW-1:0]     n_rem   [0:NST-1];
	logic [NST-1:0]     n_quo   [0:NST-1];

	// pipeline registers
	logic [NST:1]       v_s;
	logic [SEW-1:0]     s_s     [1:NST];
	logic [NST-1:0]     root_s  [1:NST];
	logic [RMW-1:0]     rrem_s  [1:NST];
	logic [NST-1:0]     nlo_s   [1:NST];
	logic [SEW-1:0]     rem_s   [1:NST];
	logic [NST-1:0]     quo_s   [1:NST];
	mqrbf_pkg::side_t   side_s  [1:NST];

	assign num1 = {in_c2, {(2 * FB){1'b0}}};

	always_comb begin
		logic [RMW-1:0] rsh;
		logic [RMW-1:0] rtr;
		logic           rge;
		logic [SEW:0]   dsh;
		logic           dge;
		ci_s[0]    = in_s;
		ci_root[0] = '0;
		ci_rrem[0] = '0;
		ci_nlo[0]  = num1[NST-1:0];
		ci_rem[0]  = SEW'(num1 >> NST);
		ci_quo[0]  = '0;
		ci_side[0] = in_side;
		for (int k = 1; k < NST; k++) begin
			ci_s[k]    = s_s[k];
			ci_root[k] = root_s[k];
			ci_rrem[k] = rrem_s[k];
			ci_nlo[k]  = nlo_s[k];
			ci_rem[k]  = rem_s[k];
			ci_quo[k]  = quo_s[k];
			ci_side[k] = side_s[k];
		end
		for (int k = 0; k < NST; k++) begin
			// one root digit: bring down the next pair of S
			rsh = {ci_rrem[k][RMW-3:0], ci_s[k][2 * (NST - 1 - k) +: 2]};
			rtr = {ci_root[k], 2'b01};
			rge = (rsh >= rtr);
			n_root[k] = {ci_root[k][NST-2:0], rge};
			n_rrem[k] = rge ? (rsh - rtr) : rsh;
			// one quotient bit of the Laplace term
			dsh = {ci_rem[k], ci_nlo[k][NST-1]};
			dge = (dsh >= {1'b0, ci_s[k]});
			n_rem[k] = dge ? SEW'(dsh - {1'b0, ci_s[k]}) : dsh[SEW-1:0];
			n_quo[k] = {ci_quo[k][NST-2:0], dge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NST-1:1], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NST; k++) begin
				s_s[k+1]    <= ci_s[k];
				root_s[k+1] <= n_root[k];
				rrem_s[k+1] <= n_rrem[k];
				nlo_s[k+1]  <= {ci_nlo[k][NST-2:0], 1'b0};
				rem_s[k+1]  <= n_rem[k];
				quo_s[k+1]  <= n_quo[k];
				side_s[k+1] <= ci_side[k];
			end
		end
	end

	assign out_v    = v_s[NST];
	assign out_root = root_s[NST];
	assign out_rrem = rrem_s[NST];
	assign out_quo  = quo_s[NST];
	assign out_side = side_s[NST];

endmodule

// File: rtl/core/mqrbf_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the final rounded quotient.
module mqrbf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_v,
	input  logic [mqrbf_pkg::N2W-1:0]     in_num,
	input  logic [mqrbf_pkg::D2W-1:0]     in_den,
	input  mqrbf_pkg::side_t              in_side,
	output logic                          out_v,
	output logic [mqrbf_pkg::Q2W-1:0]     out_quo,
	output mqrbf_pkg::side_t              out_side
);

	localparam int Q2W = mqrbf_pkg::Q2W;
	localparam int D2W = mqrbf_pkg::D2W;

	logic [D2W-1:0]     ci_den  [0:Q2W-1];
	logic [Q2W-1:0]     ci_nlo  [0:Q2W-1];
	logic [D2W-1:0]     ci_rem  [0:Q2W-1];
	logic [Q2W-1:0]     ci_quo  [0:Q2W-1];
	mqrbf_pkg::side_t   ci_side [0:Q2W-1];

	logic [D2W-1:0]     n_rem   [0:Q2W-1];
	logic               n_bit   [0:Q2W-1];

	logic [Q2W:1]       v_s;
	logic [D2W-1:0]     den_s   [1:Q2W];
	logic [Q2W-1:0]     nlo_s   [1:Q2W];
	logic [D2W-1:0]     rem_s   [1:Q2W];
	logic [Q2W-1:0]     quo_s   [1:Q2W];
	mqrbf_pkg::side_t   side_s  [1:Q2W];

	always_comb begin
		logic [D2W:0] sh;
		ci_den[0]  = in_den;
		ci_nlo[0]  = in_num[Q2W-1:0];
		ci_rem[0]  = D2W'(in_num >> Q2W);
		ci_quo[0]  = '0;
		ci_side[0] = in_side;
		for (int k = 1; k < Q2W; k++) begin
			ci_den[k]  = den_s[k];
			ci_nlo[k]  = nlo_s[k];
			ci_rem[k]  = rem_s[k];
			ci_quo[k]  = quo_s[k];
			ci_side[k] = side_s[k];
		end
		for (int k = 0; k < Q2W; k++) begin
			sh = {ci_rem[k], ci_nlo[k][Q2W-1]};
			n_bit[k] = (sh >= {1'b0, ci_den[k]});
			n_rem[k] = n_bit[k] ? D2W'(sh - {1'b0, ci_den[k]}) : sh[D2W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[Q2W-1:1], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < Q2W; k++) begin
				den_s[k+1]  <= ci_den[k];
				nlo_s[k+1]  <= {ci_nlo[k][Q2W-2:0], 1'b0};
				rem_s[k+1]  <= n_rem[k];
				quo_s[k+1]  <= {ci_quo[k][Q2W-2:0], n_bit[k]};
				side_s[k+1] <= ci_side[k];
			end
		end
	end

	assign out_v    = v_s[Q2W];
	assign out_quo  = quo_s[Q2W];
	assign out_side = side_s[Q2W];

endmodule

// File: rtl/core/multiquadric_rbf_kernel_2d.sv
// Top level of the two-dimensional multiquadric RBF kernel pipeline.
//
// Usage: present a point pair (node_i_*, node_j_*) and an operator in req_type
// on the input channel; a beat moves when in_valid is high and in_stall low.
// One result beat (basis_value, saturated, div_by_zero) leaves per input beat,
// in order, when out_valid is high and out_stall low.
// shape_param is written through cfg_wr_en / cfg_wr_data; write it only while
// no beat is in flight. Reset sets it to 1.0 and empties the pipeline.
// Throughput: one beat per cycle, sustained, as long as out_stall stays low.
// Stages: four front stages (difference, magnitude, squares, sum), 33 stages
// of the shared root / Laplace-division pipe (one root digit and one
// quotient bit each), one rounding stage, 34 stages of the final divider
// (one quotient bit each) and the output register.
// Stall: the whole pipe advances as one; while a finished result is held on
// a stalled output, in_stall is raised and every stage holds its beat.
// Identity takes the rounded root; the other operators take the rounded
// quotient. A zero S under a division operator gives 0 with div_by_zero.
module multiquadric_rbf_kernel_2d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mqrbf_pkg::SPW-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            node_i_x,
	input  logic signed [31:0]            node_i_y,
	input  logic signed [31:0]            node_j_x,
	input  logic signed [31:0]            node_j_y,
	input  logic [1:0]                    req_type,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [mqrbf_pkg::OW-1:0] basis_value,
	output logic                          saturated,
	output logic                          div_by_zero
);

	localparam int CW  = mqrbf_pkg::CW;
	localparam int FB  = mqrbf_pkg::FB;
	localparam int SPW = mqrbf_pkg::SPW;
	localparam int OW  = mqrbf_pkg::OW;
	localparam int DW  = mqrbf_pkg::DW;
	localparam int C2W = mqrbf_pkg::C2W;
	localparam int NST = mqrbf_pkg::NST;
	localparam int SEW = mqrbf_pkg::SEW;
	localparam int RMW = mqrbf_pkg::RMW;
	localparam int QW  = mqrbf_pkg::QW;
	localparam int Q2W = mqrbf_pkg::Q2W;
	localparam int N2W = mqrbf_pkg::N2W;
	localparam int D2W = mqrbf_pkg::D2W;
	localparam int MW  = mqrbf_pkg::MW;

	localparam logic [MW-1:0] NEG_LIM = MW'(1) << (OW - 1);
	localparam logic [MW-1:0] POS_LIM = NEG_LIM - MW'(1);

	logic adv;
	logic take;

	logic [SPW-1:0] shape_q;

	// stage 1: differences
	logic                   v_s1;
	logic signed [DW-1:0]   dx_s1, dy_s1;
	mqrbf_pkg::op_t         op_s1;

	// stage 2: magnitudes and sideband
	logic                   v_s2;
	logic [CW-1:0]          adx_s2, ady_s2;
	mqrbf_pkg::side_t       side_s2;

	// stage 3: squares
	logic                   v_s3;
	logic [2*CW-1:0]        ax2_s3, ay2_s3;
	logic [C2W-1:0]         c2_s3;
	mqrbf_pkg::side_t       side_s3;

	// stage 4: S
	logic                   v_s4;
	logic [SEW-1:0]         s_s4;
	logic [C2W-1:0]         c2_s4;
	mqrbf_pkg::side_t       side_s4;
	mqrbf_pkg::side_t       side4_d;

	// root / Laplace division results
	logic                   rd_v;
	logic [NST-1:0]         rd_root;
	logic [RMW-1:0]         rd_rrem;
	logic [NST-1:0]         rd_quo;
	mqrbf_pkg::side_t       rd_side;

	// stage 5: rounded root and final dividend
	logic                   v_s5;
	logic [N2W-1:0]         num_s5;
	logic [D2W-1:0]         den_s5;
	mqrbf_pkg::side_t       side_s5;

	logic [QW-1:0]          q5;
	logic [N2W-1:0]         rl5;
	mqrbf_pkg::side_t       side5_d;

	// final divider results
	logic                   dv_v;
	logic [Q2W-1:0]         dv_quo;
	mqrbf_pkg::side_t       dv_side;

	logic [MW-1:0]          mv;
	logic [OW-1:0]          val_d;
	logic                   sat_d, dz_d;

	// operator sideband: sign and magnitude of the partial's numerator
	function automatic mqrbf_pkg::side_t side2_d(
		input mqrbf_pkg::op_t         op,
		input logic signed [DW-1:0]   dx,
		input logic signed [DW-1:0]   dy
	);
		mqrbf_pkg::side_t sd;
		logic signed [DW-1:0] d;
		sd.op    = op;
		sd.szero = 1'b0;
		sd.q     = '0;
		d = (op == mqrbf_pkg::OP_YPART) ? dy : dx;
		sd.dmag = d[DW-1] ? CW'(-d) : CW'(d);
		sd.neg  = d[DW-1] && (op == mqrbf_pkg::OP_XPART || op == mqrbf_pkg::OP_YPART);
		return sd;
	endfunction

	// the whole pipe moves unless a finished beat sits on a stalled output
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign take     = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= mqrbf_pkg::SHAPE_RESET;
		end else if (cfg_wr_en) begin
			shape_q <= cfg_wr_data;
		end
	end

	// valid chain of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= take;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= rd_v;
			out_valid <= dv_v;
		end
	end

	// flag a zero S next to the sideband
	always_comb begin
		side4_d       = side_s3;
		side4_d.szero = (ax2_s3 == '0) && (ay2_s3 == '0) && (c2_s3 == '0);
	end

	// front stages: difference, magnitude, square, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DW'($signed(node_i_x[CW-1:0])) - DW'($signed(node_j_x[CW-1:0]));
			dy_s1 <= DW'($signed(node_i_y[CW-1:0])) - DW'($signed(node_j_y[CW-1:0]));
			op_s1 <= mqrbf_pkg::op_t'(req_type);

			adx_s2 <= dx_s1[DW-1] ? CW'(-dx_s1) : CW'(dx_s1);
			ady_s2 <= dy_s1[DW-1] ? CW'(-dy_s1) : CW'(dy_s1);
			side_s2 <= side2_d(op_s1, dx_s1, dy_s1);

			ax2_s3  <= adx_s2 * adx_s2;
			ay2_s3  <= ady_s2 * ady_s2;
			c2_s3   <= shape_q * shape_q;
			side_s3 <= side_s2;

			s_s4    <= SEW'(ax2_s3) + SEW'(ay2_s3) + SEW'(c2_s3);
			c2_s4   <= c2_s3;
			side_s4 <= side4_d;
		end
	end

	mqrbf_root_div u_root_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s4),
		.in_s     (s_s4),
		.in_c2    (c2_s4),
		.in_side  (side_s4),
		.out_v    (rd_v),
		.out_root (rd_root),
		.out_rrem (rd_rrem),
		.out_quo  (rd_quo),
		.out_side (rd_side)
	);

	// round the root to nearest, then build 2n + q over 2q for round half up
	always_comb begin
		q5  = QW'(rd_root) + QW'(rd_rrem > RMW'(rd_root));
		rl5 = N2W'(rd_quo) + (N2W'(1) << (2 * FB));
		side5_d   = rd_side;
		side5_d.q = q5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rd_side.op == mqrbf_pkg::OP_LAPLACE) begin
				num_s5 <= (rl5 << 1) + N2W'(q5);
			end else begin
				num_s5 <= (N2W'(rd_side.dmag) << (FB + 1)) + N2W'(q5);
			end
			den_s5  <= {q5, 1'b0};
			side_s5 <= side5_d;
		end
	end

	mqrbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s5),
		.in_num   (num_s5),
		.in_den   (den_s5),
		.in_side  (side_s5),
		.out_v    (dv_v),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// sign, clip and flag
	always_comb begin
		mv    = (dv_side.op == mqrbf_pkg::OP_IDENT) ? MW'(dv_side.q) : MW'(dv_quo);
		val_d = '0;
		sat_d = 1'b0;
		dz_d  = 1'b0;
		if (dv_side.szero) begin
			dz_d = (dv_side.op != mqrbf_pkg::OP_IDENT);
		end else if (dv_side.neg) begin
			if (mv > NEG_LIM) begin
				sat_d = 1'b1;
				val_d = OW'(NEG_LIM);
			end else begin
				val_d = OW'(-mv);
			end
		end else begin
			if (mv > POS_LIM) begin
				sat_d = 1'b1;
				val_d = OW'(POS_LIM);
			end else begin
				val_d = OW'(mv);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			basis_value <= val_d;
			saturated   <= sat_d;
			div_by_zero <= dz_d;
		end
	end

	// a zero denominator never reports a value or a clip
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_by_zero |-> basis_value == '0 && !saturated)
		else $error("div_by_zero with nonzero value or clip");

	// a clipped value sits at one of the two rails
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			basis_value == OW'(POS_LIM) || basis_value == OW'(NEG_LIM))
		else $error("saturated value off the rails");

	// input backpressure only comes from a held output beat
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output");

endmodule
